@@ rtl/button_debounce_repeat_defines.svh @@
`ifndef BUTTON_DEBOUNCE_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_REPEAT_DEFINES_SVH

// same-cycle implication
`define BDR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("button_debounce_repeat: port check failed");

// next-cycle implication
`define BDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("button_debounce_repeat: port check failed");

`endif

@@ rtl/bdr_pkg.sv @@
`timescale 1ns / 1ps

package bdr_pkg;

	localparam int PORT_BITS = 8;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_PRESS  = 3'd1,
		MODE_REPEAT = 3'd2,
		MODE_SHORT  = 3'd3,
		MODE_LONG   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_START  = 2'd1,
		REG_NEXT   = 2'd2
	} reg_idx_t;

	localparam logic [7:0] ENABLE_RST = 8'hFF;
	localparam logic [7:0] START_RST  = 8'd50;
	localparam logic [7:0] NEXT_RST   = 8'd20;

	typedef struct packed {
		logic tick;
		logic pin;
		logic clr;
	} lane_ctrl_t;

	typedef struct packed {
		logic held_q;
		logic press_q;
		logic held_nx;
		logic press_nx;
	} lane_stat_t;

	typedef struct packed {
		logic  accept;
		mode_t mode;
	} merge_ctrl_t;

endpackage

@@ rtl/bdr_lane.sv @@
`timescale 1ns / 1ps

module bdr_lane import bdr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	output lane_stat_t stat
);

	logic cnt_lo_q, cnt_hi_q, held_q, press_q;
	logic diff, cnt_lo_nx, cnt_hi_nx, flip, held_nx, press_nx;

	always_comb begin
		diff      = held_q ^ ~ctrl.pin;
		cnt_lo_nx = ~(cnt_lo_q & diff);
		cnt_hi_nx = cnt_lo_nx ^ (cnt_hi_q & diff);
		flip      = diff & cnt_lo_nx & cnt_hi_nx;
		held_nx   = held_q ^ flip;
		press_nx  = press_q | (held_nx & flip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_lo_q <= 1'b1;
			cnt_hi_q <= 1'b1;
			held_q   <= 1'b0;
			press_q  <= 1'b0;
		end else if (ctrl.tick) begin
			cnt_lo_q <= cnt_lo_nx;
			cnt_hi_q <= cnt_hi_nx;
			held_q   <= held_nx;
			press_q  <= press_nx;
		end else if (ctrl.clr) begin
			press_q <= 1'b0;
		end
	end

	assign stat = '{held_q: held_q, press_q: press_q, held_nx: held_nx, press_nx: press_nx};

endmodule

@@ rtl/bdr_merge.sv @@
`timescale 1ns / 1ps

module bdr_merge import bdr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  merge_ctrl_t          ctrl,
	input  logic [PORT_BITS-1:0] query,
	input  logic [PORT_BITS-1:0] enable,
	input  logic [7:0]           start,
	input  logic [7:0]           next,
	input  logic [PORT_BITS-1:0] held_q,
	input  logic [PORT_BITS-1:0] press_q,
	input  logic [PORT_BITS-1:0] held_nx,
	input  logic [PORT_BITS-1:0] press_nx,
	output logic [PORT_BITS-1:0] clr,
	output logic [PORT_BITS-1:0] result
);

	logic [PORT_BITS-1:0] rep_q, rep_nx, rep_tick, held_en, take, rep_take;
	logic [7:0]           cd_q, cd_nx, cd_base, cd_dec;
	logic                 expire;

	always_comb begin
		held_en  = held_nx & enable;
		cd_base  = (held_en == '0) ? start : cd_q;
		cd_dec   = cd_base - 8'd1;
		expire   = (cd_dec == 8'd0);
		rep_tick = expire ? (rep_q | held_en) : rep_q;
		rep_take = query & rep_q;
		take     = '0;
		rep_nx   = rep_q;
		cd_nx    = cd_q;
		result   = '0;
		case (ctrl.mode)
			MODE_TICK: begin
				rep_nx = rep_tick;
				cd_nx  = expire ? next : cd_dec;
				result = (press_nx | held_nx | rep_tick) & enable;
			end
			MODE_PRESS: begin
				take   = query & press_q;
				result = take;
			end
			MODE_REPEAT: begin
				rep_nx = rep_q & ~rep_take;
				result = rep_take;
			end
			MODE_SHORT: begin
				take   = query & ~held_q & press_q;
				result = take;
			end
			MODE_LONG: begin
				rep_nx = rep_q & ~rep_take;
				take   = rep_take & press_q;
				result = take;
			end
			default: begin
				result = '0;
			end
		endcase
		clr = ctrl.accept ? take : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= '0;
			cd_q  <= 8'd0;
		end else if (ctrl.accept) begin
			rep_q <= rep_nx;
			cd_q  <= cd_nx;
		end
	end

endmodule

@@ rtl/button_debounce_repeat.sv @@
`timescale 1ns / 1ps

// The result of an accepted item is registered in the output register that drives m_tdata.
// Throughput: one item per cycle while the output register is empty or m_tready is high; the single output
// register accepts a new item in the cycle its contents are taken.
// Reset: arst_n clears counters to all ones, flags, countdown and output valid,
// and loads the delay registers with their defaults; no clearing pass.
module button_debounce_repeat import bdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pin_levels [7:0], query_mask [15:8]
	input  logic [2:0]  s_tuser,   // mode [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // button_bits [7:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]           enable_q, start_q, next_q;
	logic                 cfg_wr, accept;
	reg_idx_t             reg_idx;
	logic [PORT_BITS-1:0] pins, query, enable, clr, result;
	logic [PORT_BITS-1:0] held_q, press_q, held_nx, press_nx;
	lane_ctrl_t           lane_ctrl [PORT_BITS];
	lane_stat_t           lane_stat [PORT_BITS];
	merge_ctrl_t          merge_ctrl;
	mode_t                mode;
	logic                 m_tvalid_q;
	logic [7:0]           m_tdata_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			start_q  <= START_RST;
			next_q   <= NEXT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ENABLE: enable_q <= pwdata[7:0];
				REG_START:  start_q  <= pwdata[7:0];
				REG_NEXT:   next_q   <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ENABLE: prdata = {24'd0, enable_q};
			REG_START:  prdata = {24'd0, start_q};
			REG_NEXT:   prdata = {24'd0, next_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign s_tready = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign mode     = mode_t'(s_tuser);
	assign pins     = PORT_BITS'(s_tdata[7:0]);
	assign query    = PORT_BITS'(s_tdata[15:8]);
	assign enable   = PORT_BITS'(enable_q);

	assign merge_ctrl = '{accept: accept, mode: mode};

	for (genvar i = 0; i < PORT_BITS; i++) begin : g_lane
		assign lane_ctrl[i] = '{tick: accept & (mode == MODE_TICK), pin: pins[i], clr: clr[i]};

		bdr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl[i]),
			.stat   (lane_stat[i])
		);

		assign held_q[i]   = lane_stat[i].held_q;
		assign press_q[i]  = lane_stat[i].press_q;
		assign held_nx[i]  = lane_stat[i].held_nx;
		assign press_nx[i] = lane_stat[i].press_nx;
	end

	bdr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (merge_ctrl),
		.query    (query),
		.enable   (enable),
		.start    (start_q),
		.next     (next_q),
		.held_q   (held_q),
		.press_q  (press_q),
		.held_nx  (held_nx),
		.press_nx (press_nx),
		.clr      (clr),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= 8'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/bdr_checker.sv @@
`timescale 1ns / 1ps

`include "button_debounce_repeat_defines.svh"

module bdr_checker import bdr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	logic s_acc, press_acc;

	assign s_acc     = s_tvalid & s_tready;
	assign press_acc = s_acc & (s_tuser == 3'(MODE_PRESS));

	`BDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`BDR_ASSERT_NOW(a_ready_when_free, 1'b1, s_tready == (!m_tvalid || m_tready))
	`BDR_ASSERT_NEXT(a_unused_mode_zero, s_acc && (s_tuser > 3'(MODE_LONG)),
		m_tvalid && (m_tdata == 8'd0))
	`BDR_ASSERT_NEXT(a_press_taken_once,
		press_acc && $past(press_acc) && ($past(s_tdata[15:8]) == s_tdata[15:8]),
		m_tvalid && (m_tdata == 8'd0))

endmodule

bind button_debounce_repeat bdr_checker u_bdr_checker (.*);
